// ===== src/srp_pkg.sv =====
// Shared constants, types and codes of the scratch ring player.
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

  // Ring store geometry and block limits.
  localparam int RING_DEPTH   = 262144;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int MAX_BLOCK    = 4096;
  localparam int LEN_W        = $clog2(MAX_BLOCK + 1);
  localparam int CLAMP_MARGIN = 4;

  // Field widths.
  localparam int KIND_W      = 1;
  localparam int BLOCK_LEN_W = 13;
  localparam int JOG_W       = 16;
  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_W      = 16;
  localparam int SENS_W      = 16;

  // Position arithmetic: write count in frames, playhead in Q48.16.
  localparam int WC_W   = 48;
  localparam int FRAC_W = 16;
  localparam int POS_W  = WC_W + FRAC_W;
  localparam int MOVE_W = JOG_W + SENS_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCRATCH_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE  = 2'd3;

  localparam logic [GAIN_W-1:0] SCRATCH_GAIN_RST = 16'd32768;
  localparam logic [GAIN_W-1:0] MONITOR_GAIN_RST = 16'd32768;
  localparam logic [SENS_W-1:0] SENSITIVITY_RST  = 16'd256;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_HEADER = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FRAME  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HDR_MOVE,
    ST_HDR_CLAMP,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_MIX,
    ST_OUT
  } srp_state_t;

  typedef struct packed {
    logic clear_wr;
    logic hdr_load;
    logic hdr_move;
    logic hdr_clamp;
    logic frame_start;
    logic rd_sel;
    logic cap_s0;
    logic mul;
    logic mix;
    logic load_out;
  } srp_cmd_t;

  typedef struct packed {
    logic left_zero;
    logic clear_last;
  } srp_status_t;

endpackage

`default_nettype wire

// ===== src/srp_if.sv =====
// Stream interfaces for header/frame beats in and mixed sample beats out.
`timescale 1ns / 1ps
`default_nettype none

interface srp_in_if
  import srp_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic [KIND_W-1:0]             kind;
  logic [BLOCK_LEN_W-1:0]        block_length;
  logic                          record_enable;
  logic signed [JOG_W-1:0]       jog_delta;
  logic                          jog_touched;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;

  modport source (
    output valid, kind, block_length, record_enable, jog_delta, jog_touched,
           in_left, in_right,
    input  ready
  );

  modport sink (
    input  valid, kind, block_length, record_enable, jog_delta, jog_touched,
           in_left, in_right,
    output ready
  );
endinterface

interface srp_out_if
  import srp_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  modport source (
    output valid, out_left, out_right,
    input  ready
  );

  modport sink (
    input  valid, out_left, out_right,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/srp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/srp_datapath.sv =====
// Datapath: configuration registers, ring store, playhead, interpolation and mix.
`timescale 1ns / 1ps
`default_nettype none

module srp_datapath
  import srp_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic [BLOCK_LEN_W-1:0]        block_length,
  input  wire logic                          record_enable,
  input  wire logic signed [JOG_W-1:0]       jog_delta,
  input  wire logic                          jog_touched,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right,
  input  wire srp_cmd_t                      cmd,
  output srp_status_t                        status,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right
);

  localparam int PROD_W = FRAC_W + SAMPLE_BITS + 2;
  localparam int MIXP_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int ACC_W  = MIXP_W + 1;
  localparam int MIX_SHIFT = GAIN_W - 1;

  localparam logic signed [PROD_W-1:0] INTERP_RND = PROD_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0]  MIX_RND    = ACC_W'(1 << (MIX_SHIFT - 1));
  localparam logic signed [ACC_W-1:0]  SAT_HI     = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0]  SAT_LO     = ACC_W'(-(1 << (SAMPLE_BITS - 1)));

  function automatic logic [SAMPLE_BITS-1:0] saturate(input logic signed [ACC_W-1:0] v);
    logic [SAMPLE_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [GAIN_W-1:0] scratch_gain;
  logic [GAIN_W-1:0] monitor_gain;
  logic [SENS_W-1:0] sensitivity;
  logic              stereo_mode;

  // Block state.
  logic [WC_W-1:0]  write_count;
  logic [POS_W-1:0] play_position;
  logic [LEN_W-1:0] frames_left;
  logic             block_recording;

  // Header work registers.
  logic [LEN_W-1:0]         hdr_len;
  logic                     hdr_touched;
  logic signed [MOVE_W-1:0] jog_prod;
  logic [POS_W-1:0]         pos_raw;
  logic [POS_W-1:0]         hi_q;
  logic [POS_W-1:0]         lo_q;

  // Frame work registers.
  logic [RING_AW-1:0]             clear_addr;
  logic [RING_AW-1:0]             i0_q;
  logic [FRAC_W-1:0]              frac_q;
  logic signed [SAMPLE_BITS-1:0]  live_l_q;
  logic signed [SAMPLE_BITS-1:0]  live_r_q;
  logic signed [SAMPLE_BITS-1:0]  s0_l;
  logic signed [SAMPLE_BITS-1:0]  s0_r;
  logic signed [PROD_W-1:0]       p_l;
  logic signed [PROD_W-1:0]       p_r;
  logic signed [MIXP_W-1:0]       lp_l;
  logic signed [MIXP_W-1:0]       lp_r;
  logic signed [MIXP_W-1:0]       sp_l;
  logic signed [MIXP_W-1:0]       sp_r;

  // Ring store ports.
  logic                   we_l;
  logic                   we_r;
  logic [RING_AW-1:0]     waddr;
  logic [SAMPLE_BITS-1:0] wdata_l;
  logic [SAMPLE_BITS-1:0] wdata_r;
  logic [RING_AW-1:0]     raddr;
  logic [SAMPLE_BITS-1:0] rdata_l;
  logic [SAMPLE_BITS-1:0] rdata_r;

  // Combinational intermediates.
  logic [LEN_W-1:0]              len_clamped;
  logic [RING_AW-1:0]            w_addr;
  logic                          move_neg;
  logic [MOVE_W-1:0]             move_mag;
  logic [POS_W:0]                pos_sum;
  logic [POS_W:0]                pos_dif;
  logic [POS_W-1:0]              pos_move;
  logic [WC_W:0]                 wc_p4;
  logic [WC_W:0]                 lo_int;
  logic [POS_W-1:0]              lo_next;
  logic signed [SAMPLE_BITS:0]   diff_l;
  logic signed [SAMPLE_BITS:0]   diff_r;
  logic signed [FRAC_W:0]        frac_s;
  logic signed [PROD_W-1:0]      rnd_l;
  logic signed [PROD_W-1:0]      rnd_r;
  logic signed [PROD_W-1:0]      step_l;
  logic signed [PROD_W-1:0]      step_r;
  logic signed [SAMPLE_BITS:0]   scr_wide_l;
  logic signed [SAMPLE_BITS:0]   scr_wide_r;
  logic signed [SAMPLE_BITS-1:0] scr_l;
  logic signed [SAMPLE_BITS-1:0] scr_r;
  logic signed [GAIN_W:0]        sgain_s;
  logic signed [GAIN_W:0]        mgain_s;
  logic signed [ACC_W-1:0]       acc_l;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       mix_l;
  logic signed [ACC_W-1:0]       mix_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      scratch_gain <= SCRATCH_GAIN_RST;
      monitor_gain <= MONITOR_GAIN_RST;
      sensitivity  <= SENSITIVITY_RST;
      stereo_mode  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCRATCH_GAIN: scratch_gain <= cfg_data[GAIN_W-1:0];
        CFG_MONITOR_GAIN: monitor_gain <= cfg_data[GAIN_W-1:0];
        CFG_SENSITIVITY:  sensitivity  <= cfg_data[SENS_W-1:0];
        CFG_STEREO_MODE:  stereo_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Header arithmetic.
  always_comb begin
    len_clamped = (block_length > BLOCK_LEN_W'(MAX_BLOCK))
                ? LEN_W'(MAX_BLOCK) : LEN_W'(block_length);
    w_addr = write_count[RING_AW-1:0] - RING_AW'(frames_left);

    move_neg = hdr_touched & jog_prod[MOVE_W-1];
    if (hdr_touched) begin
      move_mag = move_neg ? MOVE_W'(-jog_prod) : MOVE_W'(jog_prod);
    end else begin
      move_mag = MOVE_W'({hdr_len, FRAC_W'(0)});
    end
    pos_sum = {1'b0, play_position} + (POS_W + 1)'(move_mag);
    pos_dif = {1'b0, play_position} - (POS_W + 1)'(move_mag);
    // An underflow or overflow lands beyond the clamp limits, so the clamp
    // step settles it.
    if (write_count == '0) begin
      pos_move = '0;
    end else if (move_neg) begin
      pos_move = pos_dif[POS_W] ? '0 : pos_dif[POS_W-1:0];
    end else begin
      pos_move = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
    end

    wc_p4  = {1'b0, write_count} + (WC_W + 1)'(CLAMP_MARGIN);
    lo_int = wc_p4 - (WC_W + 1)'(RING_DEPTH);
    lo_next = (wc_p4 > (WC_W + 1)'(RING_DEPTH))
            ? {lo_int[WC_W-1:0], FRAC_W'(0)} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count     <= '0;
      play_position   <= '0;
      frames_left     <= '0;
      block_recording <= 1'b0;
      clear_addr      <= '0;
    end else begin
      if (cmd.clear_wr) begin
        clear_addr <= clear_addr + RING_AW'(1);
      end
      if (cmd.hdr_load) begin
        block_recording <= record_enable;
        frames_left     <= len_clamped;
        if (record_enable) begin
          write_count <= write_count + WC_W'(len_clamped);
        end
      end
      if (cmd.frame_start) begin
        frames_left <= frames_left - LEN_W'(1);
      end
      if (cmd.hdr_clamp) begin
        if (pos_raw < lo_q) begin
          play_position <= lo_q;
        end else if (pos_raw > hi_q) begin
          play_position <= hi_q;
        end else begin
          play_position <= pos_raw;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_load) begin
      hdr_len     <= len_clamped;
      hdr_touched <= jog_touched;
      jog_prod    <= jog_delta * $signed({1'b0, sensitivity});
    end
    if (cmd.hdr_move) begin
      pos_raw <= pos_move;
      hi_q    <= {write_count, FRAC_W'(0)};
      lo_q    <= lo_next;
    end
    if (cmd.frame_start) begin
      // Read point is the playhead minus the frames still due, this one included.
      i0_q     <= play_position[FRAC_W +: RING_AW] - RING_AW'(frames_left);
      frac_q   <= play_position[FRAC_W-1:0];
      live_l_q <= in_left;
      live_r_q <= in_right;
    end
  end

  // Ring store: the clearing pass after reset writes zeros everywhere.
  always_comb begin
    we_l    = cmd.clear_wr | (cmd.frame_start & block_recording);
    we_r    = cmd.clear_wr | (cmd.frame_start & block_recording & stereo_mode);
    waddr   = cmd.clear_wr ? clear_addr : w_addr;
    wdata_l = cmd.clear_wr ? '0 : in_left;
    wdata_r = cmd.clear_wr ? '0 : in_right;
    raddr   = cmd.rd_sel ? (i0_q + RING_AW'(1)) : i0_q;
  end

  srp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring_left (
    .clk   (clk),
    .we    (we_l),
    .waddr (waddr),
    .wdata (wdata_l),
    .raddr (raddr),
    .rdata (rdata_l)
  );

  srp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring_right (
    .clk   (clk),
    .we    (we_r),
    .waddr (waddr),
    .wdata (wdata_r),
    .raddr (raddr),
    .rdata (rdata_r)
  );

  // Interpolation and mix.
  always_comb begin
    frac_s  = $signed({1'b0, frac_q});
    sgain_s = $signed({1'b0, scratch_gain});
    mgain_s = $signed({1'b0, monitor_gain});
    diff_l  = $signed(rdata_l) - s0_l;
    diff_r  = $signed(rdata_r) - s0_r;

    rnd_l  = p_l + INTERP_RND;
    rnd_r  = p_r + INTERP_RND;
    step_l = rnd_l >>> FRAC_W;
    step_r = rnd_r >>> FRAC_W;
    scr_wide_l = s0_l + $signed(step_l[SAMPLE_BITS:0]);
    scr_wide_r = s0_r + $signed(step_r[SAMPLE_BITS:0]);
    // The interpolated value lies between its two neighbors, so it fits.
    scr_l = scr_wide_l[SAMPLE_BITS-1:0];
    scr_r = stereo_mode ? scr_wide_r[SAMPLE_BITS-1:0] : scr_wide_l[SAMPLE_BITS-1:0];

    acc_l = sp_l + lp_l + MIX_RND;
    acc_r = sp_r + lp_r + MIX_RND;
    mix_l = acc_l >>> MIX_SHIFT;
    mix_r = acc_r >>> MIX_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_s0) begin
      s0_l <= $signed(rdata_l);
      s0_r <= $signed(rdata_r);
    end
    if (cmd.mul) begin
      p_l  <= frac_s * diff_l;
      p_r  <= frac_s * diff_r;
      lp_l <= live_l_q * mgain_s;
      lp_r <= live_r_q * mgain_s;
    end
    if (cmd.mix) begin
      sp_l <= scr_l * sgain_s;
      sp_r <= scr_r * sgain_s;
    end
    if (cmd.load_out) begin
      out_left  <= saturate(mix_l);
      out_right <= saturate(mix_r);
    end
  end

  assign status.left_zero  = (frames_left == '0);
  assign status.clear_last = &clear_addr;

  a_frame_in_block: assert property (@(posedge clk) disable iff (rst)
    cmd.frame_start |-> frames_left != '0)
    else $error("frame started with no frames left in the block");

  a_frames_left_step: assert property (@(posedge clk) disable iff (rst)
    cmd.frame_start |=> frames_left == $past(frames_left) - LEN_W'(1))
    else $error("frame count did not step down by one");

  a_playhead_clamped: assert property (@(posedge clk) disable iff (rst)
    cmd.hdr_clamp |=> (play_position >= lo_q) && (play_position <= hi_q))
    else $error("playhead left its clamp window");

endmodule

`default_nettype wire

// ===== src/srp_ctrl.sv =====
// Controller: sequences the clearing pass, header update and frame steps.
`timescale 1ns / 1ps
`default_nettype none

module srp_ctrl
  import srp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [KIND_W-1:0] in_kind,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire srp_status_t       status,
  output srp_cmd_t               cmd
);

  srp_state_t state;
  srp_state_t state_next;
  logic       in_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_beat  = in_valid & in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          if (in_kind == KIND_HEADER) begin
            cmd.hdr_load = 1'b1;
            state_next   = ST_HDR_MOVE;
          end else if (!status.left_zero) begin
            cmd.frame_start = 1'b1;
            state_next      = ST_RD0;
          end
          // A frame outside a block is taken and dropped.
        end
      end
      ST_HDR_MOVE: begin
        cmd.hdr_move = 1'b1;
        state_next   = ST_HDR_CLAMP;
      end
      ST_HDR_CLAMP: begin
        cmd.hdr_clamp = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_RD0: begin
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_sel = 1'b1;
        cmd.cap_s0 = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register loaded while an untaken beat waits");

  a_header_moves: assert property (@(posedge clk) disable iff (rst)
    (in_beat && in_kind == KIND_HEADER) |=> state == ST_HDR_MOVE)
    else $error("header beat did not start the playhead update");

  a_frame_reads: assert property (@(posedge clk) disable iff (rst)
    cmd.frame_start |=> state == ST_RD0 && !in_ready)
    else $error("frame beat did not start the store reads");

endmodule

`default_nettype wire

// ===== src/scratch_ring_player_top.sv =====
// Top level of the scratch ring player.
`timescale 1ns / 1ps
`default_nettype none

// Records live stereo audio into a 262144-entry ring store and plays it back
// from a jog-controlled playhead with linear interpolation, mixed with the live
// input. After reset the block first runs a clearing pass over the whole store,
// during which din.ready stays low; configuration writes are taken at any time.
// A header beat runs through load, move and clamp of the 64-bit playhead. A
// frame beat does one store write at acceptance, then two reads through the
// single read port of the store, the interpolation multiply with the live gain
// multiply, the scratch gain multiply and the saturating output stage. The
// finished result sits in an output register, so the next beat is accepted
// while it waits on dout; only a further result stalls on it.
module scratch_ring_player_top
  import srp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  srp_in_if.sink                     din,
  srp_out_if.source                  dout
);

  srp_cmd_t    cmd;
  srp_status_t status;

  srp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_kind   (din.kind),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .status    (status),
    .cmd       (cmd)
  );

  srp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .block_length  (din.block_length),
    .record_enable (din.record_enable),
    .jog_delta     (din.jog_delta),
    .jog_touched   (din.jog_touched),
    .in_left       (din.in_left),
    .in_right      (din.in_right),
    .cmd           (cmd),
    .status        (status),
    .out_left      (dout.out_left),
    .out_right     (dout.out_right)
  );

endmodule

`default_nettype wire

// ===== bench/scratch_ring_player_top_tb.sv =====
// Testbench for scratch_ring_player_top: random header/frame beats checked by a mix scoreboard.
`timescale 1ns / 1ps

module scratch_ring_player_top_tb
  import srp_pkg::*;
;

  localparam int  HALF_PERIOD = 4;
  localparam int  RESET_CYCLES = 6;
  localparam int  SETTLE_CYCLES = 16;
  localparam int  HOLD_CYCLES = 300;
  localparam int  PHASE_ITEMS = 130;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam longint OUT_MAX = 8388607;
  localparam longint OUT_MIN = -8388608;

  typedef struct {
    logic [KIND_W-1:0]             kind;
    logic [BLOCK_LEN_W-1:0]        block_length;
    logic                          record_enable;
    logic signed [JOG_W-1:0]       jog_delta;
    logic                          jog_touched;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
  } in_beat_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
  } mix_beat_t;

  // Tracks the ring store and playhead and holds the mixed samples still due.
  class mix_scoreboard;
    bit signed [SAMPLE_BITS-1:0] store_l [RING_DEPTH];
    bit signed [SAMPLE_BITS-1:0] store_r [RING_DEPTH];
    bit [WC_W-1:0]   wr_count;
    bit [POS_W-1:0]  playhead;
    bit [POS_W-1:0]  cursor;
    bit              recording;
    bit [GAIN_W-1:0] scr_gain;
    bit [GAIN_W-1:0] mon_gain;
    bit [SENS_W-1:0] sens;
    bit              stereo;
    mix_beat_t       pending_mix[$];
    int              err_count;

    function new();
      scr_gain = SCRATCH_GAIN_RST;
      mon_gain = MONITOR_GAIN_RST;
      sens     = SENSITIVITY_RST;
      stereo   = 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SCRATCH_GAIN: scr_gain = val;
        CFG_MONITOR_GAIN: mon_gain = val;
        CFG_SENSITIVITY:  sens = val;
        CFG_STEREO_MODE:  stereo = val[0];
        default: ;
      endcase
    endfunction

    function longint lerp(bit right_ch, bit [RING_AW-1:0] i0, bit [FRAC_W-1:0] frac);
      bit [RING_AW-1:0] i1;
      longint s0, s1, p;
      i1 = i0 + 1'b1;
      s0 = right_ch ? store_r[i0] : store_l[i0];
      s1 = right_ch ? store_r[i1] : store_l[i1];
      p  = longint'(frac) * (s1 - s0) + 32768;
      return s0 + (p >>> FRAC_W);
    endfunction

    function longint mix_one(longint scr, longint live);
      longint acc;
      acc = scr * longint'(scr_gain) + live * longint'(mon_gain) + 16384;
      acc = acc >>> 15;
      if (acc > OUT_MAX) acc = OUT_MAX;
      else if (acc < OUT_MIN) acc = OUT_MIN;
      return acc;
    endfunction

    function void take_beat(in_beat_t b);
      bit [LEN_W-1:0]   len;
      bit [POS_W-1:0]   hi, lo, pos, m, sp;
      bit [WC_W-1:0]    due;
      bit [RING_AW-1:0] wa, i0;
      bit [FRAC_W-1:0]  frac;
      longint           move, sl, sr;
      mix_beat_t        r;
      if (b.kind == KIND_HEADER) begin
        len = (b.block_length > MAX_BLOCK) ? LEN_W'(MAX_BLOCK) : LEN_W'(b.block_length);
        recording = b.record_enable;
        if (recording) wr_count = wr_count + len;
        hi = POS_W'(wr_count) << FRAC_W;
        lo = (POS_W'(wr_count) + CLAMP_MARGIN > RING_DEPTH) ?
             (POS_W'(wr_count) + CLAMP_MARGIN - RING_DEPTH) << FRAC_W : '0;
        pos = playhead;
        if (wr_count == 0) begin
          pos = '0;
        end else begin
          move = b.jog_touched ? longint'(b.jog_delta) * longint'(sens)
                               : longint'(len) << FRAC_W;
          if (move < 0) begin
            m   = -move;
            pos = (pos >= m) ? pos - m : lo;
          end else begin
            m   = move;
            pos = (pos > ~m) ? hi : pos + m;
          end
        end
        if (pos < lo) pos = lo;
        if (pos > hi) pos = hi;
        playhead = pos;
        cursor   = POS_W'(len) << FRAC_W;
        return;
      end
      due = WC_W'(cursor >> FRAC_W);
      if (due == 0) return;
      if (recording) begin
        wa = RING_AW'(wr_count - due);
        store_l[wa] = b.in_left;
        if (stereo) store_r[wa] = b.in_right;
      end
      // A read before position zero wraps, which two's complement gives for free.
      sp   = playhead - cursor;
      frac = sp[FRAC_W-1:0];
      i0   = sp[FRAC_W +: RING_AW];
      sl   = lerp(1'b0, i0, frac);
      sr   = stereo ? lerp(1'b1, i0, frac) : sl;
      cursor = cursor - (POS_W'(1) << FRAC_W);
      r.out_left  = SAMPLE_BITS'(mix_one(sl, b.in_left));
      r.out_right = SAMPLE_BITS'(mix_one(sr, b.in_right));
      pending_mix.push_back(r);
    endfunction

    function void check_mix(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r);
      mix_beat_t e;
      if (pending_mix.size() == 0) begin
        $error("unexpected output beat: out_left %0d out_right %0d", l, r);
        err_count++;
        return;
      end
      e = pending_mix.pop_front();
      if (l !== e.out_left) begin
        $error("out_left mismatch: expected %0d, actual %0d", e.out_left, l);
        err_count++;
      end
      if (r !== e.out_right) begin
        $error("out_right mismatch: expected %0d, actual %0d", e.out_right, r);
        err_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srp_in_if  din_bus ();
  srp_out_if dout_bus ();

  scratch_ring_player_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_bus),
    .dout      (dout_bus)
  );

  mix_scoreboard sb = new();
  int     idle_pct;
  int     stall_pct;
  int     hold_left;
  longint cycle_count;

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Output side: check every accepted beat, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (dout_bus.valid === 1'b1 && dout_bus.ready === 1'b1)
      sb.check_mix(dout_bus.out_left, dout_bus.out_right);
    if (hold_left > 0) begin
      hold_left--;
      dout_bus.ready <= 1'b0;
    end else begin
      dout_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return 24'sh7FFFFF;
    if (pick == 1) return 24'sh800000;
    if (pick < 4) return SAMPLE_BITS'($urandom_range(2000) - 1000);
    return SAMPLE_BITS'($urandom);
  endfunction

  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      din_bus.valid <= 1'b0;
      @(posedge clk);
    end
    din_bus.valid         <= 1'b1;
    din_bus.kind          <= b.kind;
    din_bus.block_length  <= b.block_length;
    din_bus.record_enable <= b.record_enable;
    din_bus.jog_delta     <= b.jog_delta;
    din_bus.jog_touched   <= b.jog_touched;
    din_bus.in_left       <= b.in_left;
    din_bus.in_right      <= b.in_right;
    @(posedge clk);
    while (din_bus.ready !== 1'b1) @(posedge clk);
    sb.take_beat(b);
  endtask

  // Fields that the item kind does not use carry random bits.
  task automatic send_header(logic [BLOCK_LEN_W-1:0] len, logic rec,
                             logic signed [JOG_W-1:0] jog, logic touched);
    in_beat_t b;
    b.kind          = KIND_HEADER;
    b.block_length  = len;
    b.record_enable = rec;
    b.jog_delta     = jog;
    b.jog_touched   = touched;
    b.in_left       = SAMPLE_BITS'($urandom);
    b.in_right      = SAMPLE_BITS'($urandom);
    send_beat(b);
  endtask

  task automatic send_frame(logic signed [SAMPLE_BITS-1:0] l,
                            logic signed [SAMPLE_BITS-1:0] r);
    in_beat_t b;
    b.kind          = KIND_FRAME;
    b.block_length  = BLOCK_LEN_W'($urandom);
    b.record_enable = 1'($urandom_range(1));
    b.jog_delta     = JOG_W'($urandom);
    b.jog_touched   = 1'($urandom_range(1));
    b.in_left       = l;
    b.in_right      = r;
    send_beat(b);
  endtask

  task automatic settle();
    din_bus.valid <= 1'b0;
    while (sb.pending_mix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_regs(logic [GAIN_W-1:0] sg, logic [GAIN_W-1:0] mg,
                            logic [SENS_W-1:0] sens, logic stereo);
    put_reg(CFG_SCRATCH_GAIN, sg);
    put_reg(CFG_MONITOR_GAIN, mg);
    put_reg(CFG_SENSITIVITY, sens);
    put_reg(CFG_STEREO_MODE, CFG_DATA_W'(stereo));
    cfg_we <= 1'b0;
  endtask

  task automatic rand_block(inout int items);
    int                      r, nf;
    logic [BLOCK_LEN_W-1:0]  len;
    logic                    rec, touched;
    logic signed [JOG_W-1:0] jog;
    r = $urandom_range(99);
    if (r < 5) len = '0;
    else if (r < 10) len = BLOCK_LEN_W'($urandom);
    else if (r < 13) len = BLOCK_LEN_W'(MAX_BLOCK);
    else len = BLOCK_LEN_W'($urandom_range(12, 1));
    rec     = ($urandom_range(99) < 75);
    touched = 1'($urandom_range(1));
    jog     = ($urandom_range(99) < 30) ? JOG_W'($urandom) : JOG_W'($urandom_range(1024) - 512);
    // Long blocks are cut short by the next header.
    if (len <= 16) nf = ($urandom_range(99) < 10) ? $urandom_range(len) : len;
    else nf = $urandom_range(8);
    send_header(len, rec, jog, touched);
    for (int i = 0; i < nf; i++) send_frame(rand_sample(), rand_sample());
    if (nf == len && $urandom_range(99) < 8) send_frame(rand_sample(), rand_sample());
    items += 1 + nf;
  endtask

  initial begin
    int items;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = CFG_SCRATCH_GAIN;
    cfg_data              = '0;
    din_bus.valid         = 1'b0;
    din_bus.kind          = KIND_HEADER;
    din_bus.block_length  = '0;
    din_bus.record_enable = 1'b0;
    din_bus.jog_delta     = '0;
    din_bus.jog_touched   = 1'b0;
    din_bus.in_left       = '0;
    din_bus.in_right      = '0;
    dout_bus.ready        = 1'b0;
    idle_pct              = 0;
    stall_pct             = 0;
    hold_left             = 0;
    cycle_count           = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    write_regs(SCRATCH_GAIN_RST, MONITOR_GAIN_RST, SENSITIVITY_RST, 1'b1);

    // A frame with no open block is dropped.
    send_frame(24'sh123456, -24'sh1);
    // Empty block before anything is recorded keeps the playhead at zero.
    send_header('0, 1'b1, '0, 1'b0);
    // First frame reads a sample that the next frame of the block writes.
    send_header(3, 1'b1, '0, 1'b0);
    send_frame(24'sh7FFFFF, 24'sh800000);
    send_frame(24'sh800000, 24'sh7FFFFF);
    send_frame('0, -24'sh1);
    // Full jog back clamps to the floor; the reads then land before zero.
    send_header(2, 1'b0, 16'sh8000, 1'b1);
    send_frame(24'sh7FFFFF, 24'sh7FFFFF);
    send_frame(24'sh800000, 24'sh800000);
    // Half a sample forward gives a fractional read position.
    send_header(1, 1'b0, 16'sh0080, 1'b1);
    send_frame(24'sh400000, -24'sh400000);
    // Full jog forward clamps to the write count.
    send_header(2, 1'b0, 16'sh7FFF, 1'b1);
    send_frame(24'sh000001, 24'sh7FFFFF);
    send_frame(24'sh800000, 24'sh000001);
    // Oversized length acts as the maximum and is cut short by a new header.
    send_header(13'h1FFF, 1'b1, '0, 1'b0);
    send_frame(24'sh7FFFFF, 24'sh800000);
    send_frame(24'sh555555, 24'shAAAAAA);
    send_header(BLOCK_LEN_W'(MAX_BLOCK), 1'b0, 16'sh0100, 1'b1);
    send_frame(24'sh0F0F0F, 24'shF0F0F0);
    send_header(1, 1'b1, 16'shFF00, 1'b1);
    send_frame(24'sh7FFFFF, 24'sh800000);
    send_frame(24'sh000000, 24'sh000000);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_regs(SCRATCH_GAIN_RST, MONITOR_GAIN_RST, SENSITIVITY_RST, 1'b1);
        1: write_regs(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        2: write_regs(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
        3: write_regs(16'hFFFF, 16'hFFFF, 16'h0001, 1'b0);
        default: write_regs(GAIN_W'($urandom), GAIN_W'($urandom),
                            SENS_W'($urandom_range(1024)), 1'($urandom_range(1)));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      items = 0;
      if (ph == 2) begin
        // Push the write count past the ring size so the floor clamp and
        // wrapped writes come into play.
        for (int i = 0; i < 64; i++)
          send_header(BLOCK_LEN_W'(MAX_BLOCK), 1'b1, JOG_W'($urandom), 1'b0);
        items += 64;
      end
      if (ph == 0 || ph == 5) begin
        // Output held off while a block streams in, so the input backs up.
        hold_left = HOLD_CYCLES;
        send_header(12, 1'b1, '0, 1'b0);
        for (int i = 0; i < 12; i++) send_frame(rand_sample(), rand_sample());
        items += 13;
      end
      while (items < PHASE_ITEMS) rand_block(items);
      settle();
    end

    if (sb.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
